[rtl/core/sfet_pkg.sv]
// shared types and constants for the stalest-first eviction table
// no dependencies
package sfet_pkg;

	typedef enum logic [2:0] {
		CMD_REGISTER = 3'd0,
		CMD_TOUCH    = 3'd1,
		CMD_PIN      = 3'd2,
		CMD_RESIDENT = 3'd3,
		CMD_PLAN     = 3'd4,
		CMD_STATS    = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_PICK,
		S_WRITE,
		S_EMIT
	} state_t;

	localparam int ID_W    = 64;
	localparam int BYTES_W = 40;
	localparam int SUM_W   = 48;
	localparam int FRAME_W = 32;
	localparam int IN_W    = 232;
	localparam int OUT_W   = 304;
	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	// packed input request, first field highest
	typedef struct packed {
		logic [4:0]         max_count;
		logic [31:0]        min_unused;
		logic [47:0]        target_bytes;
		logic [31:0]        frame;
		logic               resident_flag;
		logic               pinned_flag;
		logic [1:0]         res_kind;
		logic [39:0]        res_bytes;
		logic [63:0]        res_id;
		logic [2:0]         command;
	} in_item_t;

	typedef struct packed {
		logic [47:0] audio_bytes;
		logic [47:0] mesh_bytes;
		logic [47:0] texture_bytes;
		logic [6:0]  resident_count;
		logic        last;
		logic [39:0] cand_bytes;
		logic [1:0]  cand_kind;
		logic [63:0] cand_id;
		logic        cand_valid;
		logic [1:0]  status;
	} out_item_t;

	// one slot's record as read from the table
	typedef struct packed {
		logic        used;
		logic [63:0] ident;
		logic [39:0] size;
		logic [1:0]  kind;
		logic        pin;
		logic        res;
		logic [31:0] touched;
	} slot_rec_t;

endpackage

[rtl/core/sfet_cmp.sv]
// shared per-slot evaluation unit: eligibility, age and best-candidate compare
// depends on sfet_pkg
module sfet_cmp import sfet_pkg::*; (
	input  slot_rec_t          rec,
	input  logic               chosen,
	input  logic [31:0]        frame,
	input  logic [31:0]        min_unused,
	input  logic               have_best,
	input  logic [31:0]        best_age,
	input  logic [39:0]        best_size,
	output logic               elig,
	output logic               better,
	output logic [31:0]        age
);
	always_comb begin
		age = (frame >= rec.touched) ? frame - rec.touched : '0;
		elig = rec.used && rec.res && !rec.pin && !chosen && (age >= min_unused);
		better = elig && (!have_best || age > best_age ||
			(age == best_age && rec.size > best_size));
	end
endmodule

[rtl/core/stalest_first_eviction_table.sv]
// stalest-first eviction table top level: slot memory, sequencer, output register
// depends on sfet_pkg and sfet_cmp
//
// channel | dir | fields
// s_axis  | in  | command res_id res_bytes res_kind pinned_flag resident_flag frame
//         |     | target_bytes min_unused max_count (tdata)
// m_axis  | out | status cand_valid cand_id cand_kind cand_bytes (tdata), last (tlast),
//         |     | resident_count texture_bytes mesh_bytes audio_bytes (tuser)
//
// every request walks the slots one per cycle through a registered read and one compare unit
// register/touch/pin/resident/stats: the walk, a drain state, then a write state that
// applies the command and loads the result register
// plan: a walk, a drain and a pick state per candidate, up to MAX_OUT candidates per request
// s_axis_tready is high only in idle; a stalled output holds the walk
// reset clears the used and chosen bits at once, the records need no clearing
module stalest_first_eviction_table import sfet_pkg::*; #(
	parameter int SLOTS   = 64,
	parameter int MAX_OUT = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [IN_W-1:0]  s_axis_tdata,  // command res_id res_bytes res_kind pinned_flag
	                                        // resident_flag frame target_bytes min_unused max_count
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	output logic [111:0]     m_axis_tdata,  // status cand_valid cand_id cand_kind cand_bytes, pad
	output logic             m_axis_tlast,
	output logic [150:0]     m_axis_tuser   // resident_count texture_bytes mesh_bytes audio_bytes
);
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(MAX_OUT + 1);

	// record storage
	logic [ID_W-1:0]    ident_mem [SLOTS];
	logic [BYTES_W-1:0] size_mem  [SLOTS];
	logic [1:0]         kind_mem  [SLOTS];
	logic [SLOTS-1:0]   pin_q, res_q, used_q, chosen_q;
	logic [31:0]        touch_mem [SLOTS];

	state_t state_q, state_d;
	in_item_t req_q;
	logic [IW-1:0] idx_q;
	logic          found_q, free_q;
	logic [IW-1:0] hit_q, free_idx_q;
	logic          have_best_q;
	logic [IW-1:0] best_q;
	logic [31:0]   best_age_q;
	logic [BYTES_W-1:0] best_size_q;
	logic [ID_W-1:0] best_id_q;
	logic [1:0]    best_kind_q;
	logic          have_elig_q, more_q;
	logic [CW-1:0] written_q, limit_q;
	logic [SUM_W:0] freed_q;
	logic [6:0]    cnt_q;
	logic [SUM_W-1:0] sum_q [3];
	out_item_t out_q;
	logic      out_v_q;

	// registered read stage of the walk
	slot_rec_t     rec_s1;
	logic          chosen_s1;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;

	logic      elig;
	logic      better;
	logic [31:0] age;
	logic idx_last, is_plan, plan_done;
	logic [SUM_W:0] add_s;

	always_ff @(posedge clk) begin
		rec_s1.used    <= used_q[idx_q];
		rec_s1.ident   <= ident_mem[idx_q];
		rec_s1.size    <= size_mem[idx_q];
		rec_s1.kind    <= kind_mem[idx_q];
		rec_s1.pin     <= pin_q[idx_q];
		rec_s1.res     <= res_q[idx_q];
		rec_s1.touched <= touch_mem[idx_q];
		chosen_s1      <= chosen_q[idx_q];
		idx_s1         <= idx_q;
	end

	sfet_cmp u_cmp (
		.rec(rec_s1), .chosen(chosen_s1), .frame(req_q.frame),
		.min_unused(req_q.min_unused), .have_best(have_best_q),
		.best_age(best_age_q), .best_size(best_size_q),
		.elig(elig), .better(better), .age(age)
	);

	assign idx_last = (idx_q == IW'(SLOTS - 1));
	assign is_plan  = (req_q.command == CMD_PLAN);
	// plan finished: candidate limit or byte target reached
	assign plan_done = (written_q >= limit_q) || (freed_q >= {1'b0, req_q.target_bytes});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (s_axis_tvalid) state_d = S_SCAN;
			S_SCAN: begin
				if (idx_last) state_d = S_DRAIN;
			end
			S_DRAIN: state_d = is_plan ? S_PICK : S_WRITE;
			S_PICK:  state_d = S_EMIT;
			S_WRITE: state_d = S_EMIT;
			S_EMIT: begin
				if (!out_v_q) begin
					if (is_plan && !out_q.last) state_d = S_SCAN;
					else state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign s_axis_tready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			used_q   <= '0;
			chosen_q <= '0;
			out_v_q  <= 1'b0;
			vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == S_SCAN);
			if (m_axis_tvalid && m_axis_tready) out_v_q <= 1'b0;
			if (state_q == S_IDLE && s_axis_tvalid) chosen_q <= '0;
			if (state_q == S_PICK && have_best_q && !plan_done && req_q.target_bytes != '0)
				chosen_q[best_q] <= 1'b1;
			if (state_q == S_WRITE && req_q.command == CMD_REGISTER &&
			    req_q.res_id != '0 && req_q.res_bytes != '0 && (found_q || free_q))
				used_q[found_q ? hit_q : free_idx_q] <= 1'b1;
			if ((state_q == S_PICK || state_q == S_WRITE)) out_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		priority case (state_q)
			S_IDLE: begin
				req_q <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
				idx_q <= '0;
				found_q <= 1'b0;
				free_q <= 1'b0;
				have_best_q <= 1'b0;
				have_elig_q <= 1'b0;
				more_q <= 1'b0;
				written_q <= '0;
				freed_q <= '0;
				cnt_q <= '0;
				sum_q[0] <= '0; sum_q[1] <= '0; sum_q[2] <= '0;
				limit_q <= (int'(s_axis_tdata[227:223]) > MAX_OUT) ? CW'(MAX_OUT)
					: CW'(s_axis_tdata[227:223]);
			end
			S_SCAN, S_DRAIN: begin
				if (state_q == S_SCAN) idx_q <= idx_last ? '0 : idx_q + 1'b1;
				if (vld_s1) begin
					if (rec_s1.used && rec_s1.ident == req_q.res_id && !found_q) begin
						found_q <= 1'b1;
						hit_q <= idx_s1;
					end
					if (!rec_s1.used && !free_q) begin
						free_q <= 1'b1;
						free_idx_q <= idx_s1;
					end
					// a second eligible slot means another pass will find one
					if (elig) begin
						have_elig_q <= 1'b1;
						if (have_elig_q) more_q <= 1'b1;
					end
					if (better) begin
						have_best_q <= 1'b1;
						best_q <= idx_s1;
						best_age_q <= age;
						best_size_q <= rec_s1.size;
						best_id_q <= rec_s1.ident;
						best_kind_q <= rec_s1.kind;
					end
					if (rec_s1.used && rec_s1.res) begin
						if (cnt_q != 7'd127) cnt_q <= cnt_q + 1'b1;
						if (rec_s1.kind != 2'd3) begin
							sum_q[rec_s1.kind] <= (add_s > {1'b0, SUM_MAX}) ? SUM_MAX
								: add_s[SUM_W-1:0];
						end
					end
				end
			end
			S_PICK: begin
				out_q <= '0;
				have_best_q <= 1'b0;
				have_elig_q <= 1'b0;
				more_q <= 1'b0;
				if (have_best_q && !plan_done && req_q.target_bytes != '0) begin
					out_q.cand_valid <= 1'b1;
					out_q.cand_id <= best_id_q;
					out_q.cand_kind <= best_kind_q;
					out_q.cand_bytes <= best_size_q;
					written_q <= written_q + 1'b1;
					freed_q <= freed_q + (SUM_W+1)'(best_size_q);
					// final candidate when this one ends the plan or none is left after it
					out_q.last <= ((written_q + 1'b1) >= limit_q) ||
						((freed_q + (SUM_W+1)'(best_size_q)) >=
						 {1'b0, req_q.target_bytes}) || !more_q;
				end else begin
					out_q.last <= 1'b1;
				end
			end
			S_WRITE: begin
				out_q <= '0;
				out_q.last <= 1'b1;
				unique case (req_q.command)
					CMD_REGISTER: begin
						if (req_q.res_id == '0 || req_q.res_bytes == '0)
							out_q.status <= ST_INVALID;
						else if (!found_q && !free_q)
							out_q.status <= ST_FULL;
					end
					CMD_TOUCH, CMD_PIN, CMD_RESIDENT:
						if (!found_q) out_q.status <= ST_NOTFOUND;
					CMD_STATS: begin
						out_q.resident_count <= cnt_q;
						out_q.texture_bytes <= sum_q[0];
						out_q.mesh_bytes <= sum_q[1];
						out_q.audio_bytes <= sum_q[2];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign add_s = {1'b0, sum_q[rec_s1.kind]} + (SUM_W+1)'(rec_s1.size);

	// record writes
	logic [IW-1:0] wi;
	assign wi = found_q ? hit_q : free_idx_q;
	always_ff @(posedge clk) begin
		if (state_q == S_WRITE) begin
			unique case (req_q.command)
				CMD_REGISTER: if (req_q.res_id != '0 && req_q.res_bytes != '0 &&
				                  (found_q || free_q)) begin
					ident_mem[wi] <= req_q.res_id;
					size_mem[wi]  <= req_q.res_bytes;
					kind_mem[wi]  <= req_q.res_kind;
					pin_q[wi]     <= req_q.pinned_flag;
					res_q[wi]     <= req_q.resident_flag;
					touch_mem[wi] <= req_q.frame;
				end
				CMD_TOUCH: if (found_q) touch_mem[hit_q] <= req_q.frame;
				CMD_PIN:   if (found_q) pin_q[hit_q] <= req_q.pinned_flag;
				CMD_RESIDENT: if (found_q) begin
					res_q[hit_q] <= req_q.resident_flag;
					touch_mem[hit_q] <= req_q.frame;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {3'b000, out_q.cand_bytes, out_q.cand_kind, out_q.cand_id,
		out_q.cand_valid, out_q.status};
	assign m_axis_tlast  = out_q.last;
	assign m_axis_tuser  = {out_q.audio_bytes, out_q.mesh_bytes, out_q.texture_bytes,
		out_q.resident_count};
endmodule

[rtl/core/sfet_chk.sv]
// port-level checks for the eviction table
// depends on sfet_pkg; bound to stalest_first_eviction_table
module sfet_chk import sfet_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [111:0] m_axis_tdata,
	input logic         m_axis_tlast,
	input logic [150:0] m_axis_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("ready right after request");
	a_nocand_stats: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tuser == '0)
		else $error("candidate carries stats");
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_axis_tvalid && s_axis_tready))
		else $error("accepting while result pending");
	a_candlast: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tlast)
		else $error("error status without last");
endmodule

bind stalest_first_eviction_table sfet_chk u_chk (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast), .m_axis_tuser(m_axis_tuser)
);
